/* rtl/edm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edm_pkg
// Shared constants, widths and types of the distance-matrix row engine.
// ----------------------------------------------------------------------------
package edm_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 24;

    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int IDX_W      = 6;
    localparam int PC_W       = 7;
    localparam int DIST_W     = 26;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 26;

    localparam int PT_W       = 2 * COORD_BITS;
    localparam int DIFF_W     = COORD_BITS;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int RAD_W      = SQ_W + 1;
    localparam int ROOT_W     = (RAD_W + 1) / 2;
    localparam int RAD_PAD_W  = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int STEP_W     = $clog2(ROOT_W + 1);
    localparam int EXT_W      = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;

    localparam logic [DIST_W-1:0] DIAG_RESET = DIST_W'(999999);

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIAGONAL    = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ROW  = 1'b1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PT_W-1:0]   data;
    } t_mem_wr;

    typedef struct packed {
        logic             go;
        logic [RAD_W-1:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_rsp;

endpackage

/* rtl/edm_point_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edm_point_mem
// Point store: one write port, one registered read port, x and y per word.
// ----------------------------------------------------------------------------
module edm_point_mem
    import edm_pkg::*;
(
    input  logic              i_clk,
    input  t_mem_wr           i_wr,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [PT_W-1:0]   o_rd_data
);

    logic [PT_W-1:0] r_mem [MAX_POINTS];
    logic [PT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/edm_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edm_sqrt
// Integer square root, restoring method, one root bit per cycle.
// ----------------------------------------------------------------------------
module edm_sqrt
    import edm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sqrt_req i_req,
    output t_sqrt_rsp o_rsp
);

    logic [RAD_PAD_W-1:0] r_rad;
    logic [REM_W-1:0]     r_rem;
    logic [ROOT_W-1:0]    r_root;
    logic [STEP_W-1:0]    r_step;
    logic                 r_done;

    logic [REM_W-1:0]     rem_sh;
    logic [REM_W-1:0]     trial;
    logic                 fit;

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_PAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign fit    = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_rad  <= RAD_PAD_W'(i_req.radicand);
                r_rem  <= '0;
                r_root <= '0;
                r_step <= STEP_W'(ROOT_W);
            end else if (r_step != '0) begin
                r_rad  <= r_rad << 2;
                r_rem  <= fit ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[ROOT_W-2:0], fit};
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

/* rtl/edm_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edm_seq
// Row sequencer: point loads, column walk, shared squarer, result words.
// ----------------------------------------------------------------------------
module edm_seq
    import edm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_op,
    input  logic [IDX_W-1:0]      i_index,
    input  logic [COORD_BITS-1:0] i_coord_x,
    input  logic [COORD_BITS-1:0] i_coord_y,
    input  logic [PC_W-1:0]       i_count,
    input  logic [DIST_W-1:0]     i_diag,
    output t_mem_wr               o_mem_wr,
    output logic [ADDR_W-1:0]     o_mem_rd_addr,
    input  logic [PT_W-1:0]       i_mem_rd_data,
    output t_sqrt_req             o_sqrt_req,
    input  t_sqrt_rsp             i_sqrt_rsp,
    output logic                  o_busy,
    output logic                  o_result_valid,
    output logic [DIST_W-1:0]     o_distance,
    output logic [IDX_W-1:0]      o_column,
    output logic                  o_last_in_row,
    output logic                  o_row_error
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW_RD,
        S_ROW_LATCH,
        S_COL_RD,
        S_COL_DIFF,
        S_SQ_X,
        S_SQ_Y,
        S_ADD,
        S_ROOT_WAIT
    } t_state;

    t_state                  r_state;
    logic [IDX_W-1:0]        r_row;
    logic [ADDR_W-1:0]       r_col;
    logic [COORD_BITS-1:0]   r_row_x;
    logic [COORD_BITS-1:0]   r_row_y;
    logic [DIFF_W-1:0]       r_dx;
    logic [DIFF_W-1:0]       r_dy;
    logic [SQ_W-1:0]         r_prod;
    logic [SQ_W-1:0]         r_acc;
    logic [RAD_W-1:0]        r_rad;
    logic                    r_sqrt_go;
    logic                    r_valid;
    logic [DIST_W-1:0]       r_distance;
    logic [IDX_W-1:0]        r_column;
    logic                    r_last;
    logic                    r_error;

    logic [COORD_BITS-1:0]   col_x;
    logic [COORD_BITS-1:0]   col_y;
    logic [DIFF_W-1:0]       sq_operand;
    logic [SQ_W-1:0]         sq_result;
    logic                    col_last;
    logic                    row_bad;
    logic [EXT_W-1:0]        root_ext;
    logic [DIST_W-1:0]       root_sat;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                   input logic [COORD_BITS-1:0] b);
        logic signed [COORD_BITS:0] d;
        logic signed [COORD_BITS:0] m;
        d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
        m = d[COORD_BITS] ? -d : d;
        return m[DIFF_W-1:0];
    endfunction

    assign {col_x, col_y} = i_mem_rd_data;

    // one squarer, shared between dx and dy
    assign sq_operand = (r_state == S_SQ_X) ? r_dx : r_dy;
    assign sq_result  = sq_operand * sq_operand;

    assign col_last = ((PC_W'(r_col) + PC_W'(1)) == i_count);
    assign row_bad  = ({1'b0, i_index} >= i_count);

    assign root_ext = EXT_W'(i_sqrt_rsp.root);
    assign root_sat = ((root_ext >> DIST_W) != '0) ? '1 : root_ext[DIST_W-1:0];

    assign o_mem_wr.en   = (r_state == S_IDLE) && i_start && (i_op == OP_LOAD)
                           && ({1'b0, i_index} < (IDX_W + 1)'(MAX_POINTS));
    assign o_mem_wr.addr = i_index[ADDR_W-1:0];
    assign o_mem_wr.data = {i_coord_x, i_coord_y};
    assign o_mem_rd_addr = (r_state == S_ROW_RD) ? r_row[ADDR_W-1:0] : r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_sqrt_go <= 1'b0;
        end else begin
            r_valid   <= 1'b0;
            r_sqrt_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start && (i_op == OP_ROW)) begin
                        r_row <= i_index;
                        r_col <= '0;
                        if (row_bad) begin
                            r_valid    <= 1'b1;
                            r_distance <= '0;
                            r_column   <= i_index;
                            r_last     <= 1'b1;
                            r_error    <= 1'b1;
                        end else begin
                            r_state <= S_ROW_RD;
                        end
                    end
                end
                S_ROW_RD: begin
                    r_state <= S_ROW_LATCH;
                end
                S_ROW_LATCH: begin
                    r_row_x <= col_x;
                    r_row_y <= col_y;
                    r_state <= S_COL_RD;
                end
                S_COL_RD: begin
                    if (IDX_W'(r_col) == r_row) begin
                        r_valid    <= 1'b1;
                        r_distance <= i_diag;
                        r_column   <= IDX_W'(r_col);
                        r_last     <= col_last;
                        r_error    <= 1'b0;
                        r_col      <= r_col + ADDR_W'(1);
                        r_state    <= col_last ? S_IDLE : S_COL_RD;
                    end else begin
                        r_state <= S_COL_DIFF;
                    end
                end
                S_COL_DIFF: begin
                    r_dx    <= abs_diff(col_x, r_row_x);
                    r_dy    <= abs_diff(col_y, r_row_y);
                    r_state <= S_SQ_X;
                end
                S_SQ_X: begin
                    r_prod  <= sq_result;
                    r_state <= S_SQ_Y;
                end
                S_SQ_Y: begin
                    r_acc   <= r_prod;
                    r_prod  <= sq_result;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_rad     <= RAD_W'(r_acc) + RAD_W'(r_prod);
                    r_sqrt_go <= 1'b1;
                    r_state   <= S_ROOT_WAIT;
                end
                S_ROOT_WAIT: begin
                    if (i_sqrt_rsp.done) begin
                        r_valid    <= 1'b1;
                        r_distance <= root_sat;
                        r_column   <= IDX_W'(r_col);
                        r_last     <= col_last;
                        r_error    <= 1'b0;
                        r_col      <= r_col + ADDR_W'(1);
                        r_state    <= col_last ? S_IDLE : S_COL_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_sqrt_req.go       = r_sqrt_go;
    assign o_sqrt_req.radicand = r_rad;

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_distance     = r_distance;
    assign o_column       = r_column;
    assign o_last_in_row  = r_last;
    assign o_row_error    = r_error;

endmodule

/* rtl/euclidean_distance_matrix_row.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclidean_distance_matrix_row
// Point store and distance-matrix row engine over signed fixed-point points.
// ----------------------------------------------------------------------------
// A load is written into the store and busy stays low. A row walks the first
// point_count stored points (at most the store depth) in column order:
// S_ROW_RD and S_ROW_LATCH fetch the row point, the diagonal column takes its
// word from the diagonal register, and every other column passes S_COL_RD,
// S_COL_DIFF, the shared squarer, S_ADD and the one-bit-per-cycle square root
// unit. An empty or out-of-range row gives its error word in the cycle after
// start. Each result word is shown for one cycle under o_result_valid and
// there is no back-pressure: the receiver must take every word as it comes.
// Configuration writes are always ready and belong in idle periods.
// ----------------------------------------------------------------------------
module euclidean_distance_matrix_row
    import edm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_op,
    input  logic [IDX_W-1:0]      i_index,
    input  logic [COORD_BITS-1:0] i_coord_x,
    input  logic [COORD_BITS-1:0] i_coord_y,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_result_valid,
    output logic [DIST_W-1:0]     o_distance,
    output logic [IDX_W-1:0]      o_column,
    output logic                  o_last_in_row,
    output logic                  o_row_error
);

    logic [PC_W-1:0]   r_point_count;
    logic [DIST_W-1:0] r_diagonal;

    logic [PC_W-1:0]   count_eff;
    t_mem_wr           mem_wr;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [PT_W-1:0]   mem_rd_data;
    t_sqrt_req         sqrt_req;
    t_sqrt_rsp         sqrt_rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
            r_diagonal    <= DIAG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_POINT_COUNT: r_point_count <= i_cfg_data[PC_W-1:0];
                REG_DIAGONAL:    r_diagonal    <= i_cfg_data[DIST_W-1:0];
                default:         r_point_count <= r_point_count;
            endcase
        end
    end

    // counts above the store depth act as a full store
    assign count_eff = (r_point_count > PC_W'(MAX_POINTS)) ? PC_W'(MAX_POINTS)
                                                           : r_point_count;

    edm_point_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    edm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_rsp   (sqrt_rsp)
    );

    edm_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_op           (i_op),
        .i_index        (i_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_count        (count_eff),
        .i_diag         (r_diagonal),
        .o_mem_wr       (mem_wr),
        .o_mem_rd_addr  (mem_rd_addr),
        .i_mem_rd_data  (mem_rd_data),
        .o_sqrt_req     (sqrt_req),
        .i_sqrt_rsp     (sqrt_rsp),
        .o_busy         (busy),
        .o_result_valid (o_result_valid),
        .o_distance     (o_distance),
        .o_column       (o_column),
        .o_last_in_row  (o_last_in_row),
        .o_row_error    (o_row_error)
    );

    // a bad row gives its error word on the very next cycle
    a_bad_row_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == OP_ROW) && ({1'b0, i_index} >= count_eff))
        |=> (o_result_valid && o_row_error && o_last_in_row))
        else $error("bad row did not give a single error word");

    // the last word of a row leaves the sequencer idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_in_row) |-> !busy)
        else $error("sequencer still busy after last word");

    // no word of a valid row lands outside the columns in use
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_row_error && $stable(count_eff))
        |-> ({1'b0, o_column} < count_eff))
        else $error("result column beyond point count");

    // the root unit never gets its go request back to back
    a_sqrt_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_req.go |=> !sqrt_req.go)
        else $error("square root restarted back to back");

endmodule

/* sim/edm_distance_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edm_distance_checker
// Watches the distance-matrix row engine and scores every result word.
// ----------------------------------------------------------------------------
// Keeps its own copy of the point store and of both registers. Each accepted
// row request is expanded into the words it must produce: one per column in
// use, or a single error word. Every result word is compared field by field
// against the oldest word still due. The number of words due and the failure
// count go to the testbench top.
// ----------------------------------------------------------------------------
module edm_distance_checker
    import edm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic                  i_op,
    input  logic [IDX_W-1:0]      i_index,
    input  logic [COORD_BITS-1:0] i_coord_x,
    input  logic [COORD_BITS-1:0] i_coord_y,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_result_valid,
    input  logic [DIST_W-1:0]     i_distance,
    input  logic [IDX_W-1:0]      i_column,
    input  logic                  i_last_in_row,
    input  logic                  i_row_error,
    output int                    o_words_due,
    output int                    o_fail_count
);

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  column;
        logic              last_in_row;
        logic              row_error;
    } t_dist_word;

    t_dist_word                   pending_words[$];
    t_dist_word                   want;
    logic signed [COORD_BITS-1:0] pt_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] pt_y [MAX_POINTS];
    logic [PC_W-1:0]              point_count;
    logic [DIST_W-1:0]            diag_value;
    int                           fails = 0;

    // bit-pair restoring square root, floor of the exact root
    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = n;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic logic [DIST_W-1:0] point_gap(input int a, input int b);
        longint      dx;
        longint      dy;
        logic [63:0] root;
        dx = longint'(pt_x[a]) - longint'(pt_x[b]);
        dy = longint'(pt_y[a]) - longint'(pt_y[b]);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        root = floor_sqrt(64'(dx * dx + dy * dy));
        // saturate, only reachable with wider coordinates
        if ((root >> DIST_W) != 0)
            return '1;
        return root[DIST_W-1:0];
    endfunction

    function automatic void predict_row(input logic [IDX_W-1:0] row);
        int         cols;
        t_dist_word w;
        cols = (point_count > MAX_POINTS) ? MAX_POINTS : int'(point_count);
        if (int'(row) >= cols) begin
            w.distance    = '0;
            w.column      = row;
            w.last_in_row = 1'b1;
            w.row_error   = 1'b1;
            pending_words.insert(pending_words.size(), w);
        end else begin
            for (int j = 0; j < cols; j++) begin
                w.distance    = (j == int'(row)) ? diag_value : point_gap(int'(row), j);
                w.column      = IDX_W'(j);
                w.last_in_row = (j == cols - 1);
                w.row_error   = 1'b0;
                pending_words.insert(pending_words.size(), w);
            end
        end
    endfunction

    function automatic void check_field(input string what, input logic [DIST_W-1:0] exp_v,
                                        input logic [DIST_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s of word for column %0d expected %0d, got %0d",
                     $time, what, want.column, exp_v, act_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            point_count = '0;
            diag_value  = DIAG_RESET;
            pending_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_POINT_COUNT)
                    point_count = i_cfg_data[PC_W-1:0];
                else if (i_cfg_index == REG_DIAGONAL)
                    diag_value = i_cfg_data[DIST_W-1:0];
            end
            // older words are scored before a request at this edge adds more
            if (i_result_valid) begin
                if (pending_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got distance %0d column %0d",
                             $time, i_distance, i_column);
                    fails++;
                end else begin
                    want = pending_words.pop_front();
                    check_field("distance", want.distance, i_distance);
                    check_field("column", DIST_W'(want.column), DIST_W'(i_column));
                    check_field("last_in_row", DIST_W'(want.last_in_row),
                                DIST_W'(i_last_in_row));
                    check_field("row_error", DIST_W'(want.row_error), DIST_W'(i_row_error));
                end
            end
            if (i_start && !i_busy) begin
                if (i_op == OP_LOAD) begin
                    pt_x[i_index] = i_coord_x;
                    pt_y[i_index] = i_coord_y;
                end else begin
                    predict_row(i_index);
                end
            end
        end
        o_words_due  <= pending_words.size();
        o_fail_count <= fails;
    end

endmodule

/* sim/tb_euclidean_distance_matrix_row.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euclidean_distance_matrix_row
// Stimulus and verdict for the distance-matrix row engine.
// ----------------------------------------------------------------------------
// A short directed run covers coordinate extremes, the zero and single point
// counts, both diagonal extremes and error rows. Then a series of register
// settings follows, from tiny counts up to a full store and a count past the
// store size, each with random loads and rows. Every slot in use is loaded
// before a row can read it. Sender gaps vary between settings. Scoring is
// done by the checker beside the block; a watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module tb_euclidean_distance_matrix_row;
    import edm_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = COORD_BITS + 16;
    localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
    localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};
    localparam logic [CFG_DATA_W-1:0] DIAG_MAX = {CFG_DATA_W{1'b1}};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_op;
    logic [IDX_W-1:0]      i_index;
    logic [COORD_BITS-1:0] i_coord_x;
    logic [COORD_BITS-1:0] i_coord_y;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_result_valid;
    logic [DIST_W-1:0]     o_distance;
    logic [IDX_W-1:0]      o_column;
    logic                  o_last_in_row;
    logic                  o_row_error;

    int              words_due;
    int              fail_count;
    int              quiet_cycles;
    int              idle_pct;
    int              cols_in_use;
    int              hub;
    logic [MAX_POINTS-1:0] loaded_slots;
    int              setting_counts[12] = '{3, 64, 8, 0, 16, 127, 2, 5, 1, 33, 12, 7};

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    euclidean_distance_matrix_row i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_index        (i_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_distance     (o_distance),
        .o_column       (o_column),
        .o_last_in_row  (o_last_in_row),
        .o_row_error    (o_row_error)
    );

    edm_distance_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_op           (i_op),
        .i_index        (i_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_result_valid (o_result_valid),
        .i_distance     (o_distance),
        .i_column       (o_column),
        .i_last_in_row  (o_last_in_row),
        .i_row_error    (o_row_error),
        .o_words_due    (words_due),
        .o_fail_count   (fail_count)
    );

    // watchdog: any accepted word on any channel counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL euclidean_distance_matrix_row");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // start is left high on return so back-to-back words need no extra edge
    task automatic issue(input logic op, input logic [IDX_W-1:0] idx,
                         input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_op      <= op;
        i_index   <= idx;
        i_coord_x <= x;
        i_coord_y <= y;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (op == OP_LOAD)
            loaded_slots[idx] = 1'b1;
    endtask

    // wait for every word due, then give a trailing load time to settle
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (words_due != 0 || busy);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input int count, input logic [CFG_DATA_W-1:0] diag);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_POINT_COUNT;
        i_cfg_data  <= CFG_DATA_W'(count);
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_index <= REG_DIAGONAL;
        i_cfg_data  <= diag;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cols_in_use = (count > MAX_POINTS) ? MAX_POINTS : count;
    endtask

    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(9))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2, 3, 4: return COORD_BITS'($urandom);
            default: return COORD_BITS'(hub + int'($urandom_range(511)) - 256);
        endcase
    endfunction

    task automatic random_item();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) begin
            issue(OP_LOAD, IDX_W'($urandom_range(MAX_POINTS - 1)), pick_coord(), pick_coord());
        end else if (cols_in_use == 0 || (roll >= 85 && cols_in_use < MAX_POINTS)) begin
            issue(OP_ROW, IDX_W'($urandom_range(63, cols_in_use)),
                  COORD_BITS'($urandom), COORD_BITS'($urandom));
        end else begin
            issue(OP_ROW, IDX_W'($urandom_range(cols_in_use - 1)),
                  COORD_BITS'($urandom), COORD_BITS'($urandom));
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_op         <= OP_LOAD;
        i_index      <= '0;
        i_coord_x    <= '0;
        i_coord_y    <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= REG_POINT_COUNT;
        i_cfg_data   <= '0;
        idle_pct     = 0;
        cols_in_use  = 0;
        hub          = 0;
        loaded_slots = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // count is zero out of reset, so every row is an error word
        issue(OP_ROW, 0, '0, '0);
        issue(OP_ROW, 63, '1, '1);
        issue(OP_LOAD, 0, COORD_MAX, COORD_MAX);
        issue(OP_LOAD, 1, COORD_MIN, COORD_MIN);
        issue(OP_LOAD, 2, '0, '0);
        issue(OP_LOAD, 3, COORD_MAX, COORD_MIN);
        issue(OP_LOAD, 63, COORD_BITS'(3), '1);
        issue(OP_ROW, 0, '0, '0);

        // single point: the lone word is the diagonal and closes the row
        write_config(1, '0);
        issue(OP_ROW, 0, '0, '0);
        issue(OP_ROW, 1, '0, '0);

        // opposite corners give the widest distance
        write_config(4, DIAG_MAX);
        issue(OP_ROW, 0, '0, '0);
        issue(OP_ROW, 1, '0, '0);
        issue(OP_ROW, 3, '0, '0);
        issue(OP_ROW, 4, '0, '0);
        issue(OP_ROW, 63, '0, '0);
        issue(OP_LOAD, 2, COORD_BITS'(3), COORD_BITS'(4));
        issue(OP_LOAD, 1, '0, '0);
        issue(OP_ROW, 2, '0, '0);

        for (int s = 0; s < 12; s++) begin
            case (s)
                4:       write_config(setting_counts[s], DIAG_MAX);
                7:       write_config(setting_counts[s], '0);
                default: write_config(setting_counts[s], CFG_DATA_W'($urandom));
            endcase
            case (s % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 57;
                default: idle_pct = 8;
            endcase
            hub = $urandom;
            // every slot a row can read is loaded first
            for (int j = 0; j < cols_in_use; j++) begin
                if (!loaded_slots[j])
                    issue(OP_LOAD, IDX_W'(j), pick_coord(), pick_coord());
            end
            repeat ((cols_in_use >= 32) ? 10 : 26) random_item();
        end

        settle();
        if (fail_count == 0) begin
            $display("PASS euclidean_distance_matrix_row");
        end else begin
            $display("FAIL euclidean_distance_matrix_row");
        end
        $finish;
    end

endmodule

/* euclidean_distance_matrix_row.f */
rtl/edm_pkg.sv
rtl/edm_point_mem.sv
rtl/edm_sqrt.sv
rtl/edm_seq.sv
rtl/euclidean_distance_matrix_row.sv
sim/edm_distance_checker.sv
sim/tb_euclidean_distance_matrix_row.sv
